[sv/swpc_pkg.sv]
// ----------------------------------------------------------------------------
// swpc_pkg
// Types, control-word layout and microprogram of the pair counter.
// ----------------------------------------------------------------------------
package swpc_pkg;

  localparam int ELEM_INDEX_W = 10;
  localparam int ELEM_VALUE_W = 10;
  localparam int RANGE_W      = 11;
  localparam int PAIR_COUNT_W = 10;
  localparam int S_TDATA_W    = 48;
  localparam int M_TDATA_W    = 16;
  localparam int STEP_W       = 5;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [3:0] {
    C_ALWAYS,
    C_NEVER,
    C_NO_FIRE,
    C_IS_LOAD,
    C_REVERSED,
    C_END_GE_QE,
    C_START_LE_QS,
    C_START_GE_QS,
    C_END_LE_QE,
    C_NOT_INSIDE,
    C_LOAD_SKIP,
    C_OUT_FULL,
    C_CLR_BUSY
  } cond_e;

  typedef enum logic [2:0] {
    ST_END,
    ST_START_M1,
    ST_START,
    ST_END_M1,
    ST_LOAD_IDX
  } st_sel_e;

  typedef enum logic {
    PS_STORE_DATA,
    PS_LOAD_VAL
  } par_sel_e;

  typedef enum logic [1:0] {
    PO_NONE,
    PO_ADD,
    PO_REMOVE,
    PO_CLEAR
  } par_op_e;

  typedef enum logic [2:0] {
    WO_NONE,
    WO_INC_END,
    WO_DEC_START,
    WO_INC_START,
    WO_DEC_END
  } win_op_e;

  typedef struct packed {
    cond_e    cond;
    step_t    target;
    logic     in_ready;
    logic     emit;
    logic     st_rd;
    logic     st_wr;
    st_sel_e  st_sel;
    logic     par_rd;
    par_sel_e par_sel;
    par_op_e  par_op;
    win_op_e  win_op;
  } ctrl_t;

  typedef struct packed {
    logic is_load;
    logic reversed;
    logic end_ge_qe;
    logic start_le_qs;
    logic start_ge_qs;
    logic end_le_qe;
    logic not_inside;
    logic load_skip;
    logic clr_busy;
  } dp_flags_t;

  localparam step_t S_CLEAR      = 5'd0;
  localparam step_t S_WAIT       = 5'd1;
  localparam step_t S_DECODE     = 5'd2;
  localparam step_t S_CHK_REV    = 5'd3;
  localparam step_t S_GROW_END   = 5'd4;
  localparam step_t S_GE_RD      = 5'd5;
  localparam step_t S_GE_PAR     = 5'd6;
  localparam step_t S_GE_UPD     = 5'd7;
  localparam step_t S_GROW_START = 5'd8;
  localparam step_t S_GS_RD      = 5'd9;
  localparam step_t S_GS_PAR     = 5'd10;
  localparam step_t S_GS_UPD     = 5'd11;
  localparam step_t S_SHR_START  = 5'd12;
  localparam step_t S_SS_RD      = 5'd13;
  localparam step_t S_SS_PAR     = 5'd14;
  localparam step_t S_SS_UPD     = 5'd15;
  localparam step_t S_SHR_END    = 5'd16;
  localparam step_t S_SE_RD      = 5'd17;
  localparam step_t S_SE_PAR     = 5'd18;
  localparam step_t S_SE_UPD     = 5'd19;
  localparam step_t S_EMIT       = 5'd20;
  localparam step_t S_RETURN     = 5'd21;
  localparam step_t S_LOAD       = 5'd22;
  localparam step_t S_LD_CHK_IN  = 5'd23;
  localparam step_t S_LD_OLD_RD  = 5'd24;
  localparam step_t S_LD_OLD_PAR = 5'd25;
  localparam step_t S_LD_OLD_UPD = 5'd26;
  localparam step_t S_LD_WRITE   = 5'd27;
  localparam step_t S_LD_NEW_PAR = 5'd28;
  localparam step_t S_LD_NEW_UPD = 5'd29;

  localparam ctrl_t CW_NOP = '{
    cond:     C_NEVER,
    target:   S_WAIT,
    in_ready: 1'b0,
    emit:     1'b0,
    st_rd:    1'b0,
    st_wr:    1'b0,
    st_sel:   ST_END,
    par_rd:   1'b0,
    par_sel:  PS_STORE_DATA,
    par_op:   PO_NONE,
    win_op:   WO_NONE
  };

  function automatic ctrl_t ucode(input step_t step);
    ctrl_t c;
    c = CW_NOP;
    case (step)
      S_CLEAR: begin
        c.par_op = PO_CLEAR;
        c.cond   = C_CLR_BUSY;
        c.target = S_CLEAR;
      end
      S_WAIT: begin
        c.in_ready = 1'b1;
        c.cond     = C_NO_FIRE;
        c.target   = S_WAIT;
      end
      S_DECODE: begin
        c.cond   = C_IS_LOAD;
        c.target = S_LOAD;
      end
      S_CHK_REV: begin
        c.cond   = C_REVERSED;
        c.target = S_EMIT;
      end
      S_GROW_END: begin
        c.cond   = C_END_GE_QE;
        c.target = S_GROW_START;
      end
      S_GE_RD: begin
        c.st_rd  = 1'b1;
        c.st_sel = ST_END;
      end
      S_GE_PAR: c.par_rd = 1'b1;
      S_GE_UPD: begin
        c.par_op = PO_ADD;
        c.win_op = WO_INC_END;
        c.cond   = C_ALWAYS;
        c.target = S_GROW_END;
      end
      S_GROW_START: begin
        c.cond   = C_START_LE_QS;
        c.target = S_SHR_START;
      end
      S_GS_RD: begin
        c.st_rd  = 1'b1;
        c.st_sel = ST_START_M1;
      end
      S_GS_PAR: c.par_rd = 1'b1;
      S_GS_UPD: begin
        c.par_op = PO_ADD;
        c.win_op = WO_DEC_START;
        c.cond   = C_ALWAYS;
        c.target = S_GROW_START;
      end
      S_SHR_START: begin
        c.cond   = C_START_GE_QS;
        c.target = S_SHR_END;
      end
      S_SS_RD: begin
        c.st_rd  = 1'b1;
        c.st_sel = ST_START;
      end
      S_SS_PAR: c.par_rd = 1'b1;
      S_SS_UPD: begin
        c.par_op = PO_REMOVE;
        c.win_op = WO_INC_START;
        c.cond   = C_ALWAYS;
        c.target = S_SHR_START;
      end
      S_SHR_END: begin
        c.cond   = C_END_LE_QE;
        c.target = S_EMIT;
      end
      S_SE_RD: begin
        c.st_rd  = 1'b1;
        c.st_sel = ST_END_M1;
      end
      S_SE_PAR: c.par_rd = 1'b1;
      S_SE_UPD: begin
        c.par_op = PO_REMOVE;
        c.win_op = WO_DEC_END;
        c.cond   = C_ALWAYS;
        c.target = S_SHR_END;
      end
      S_EMIT: begin
        c.emit   = 1'b1;
        c.cond   = C_OUT_FULL;
        c.target = S_EMIT;
      end
      S_RETURN: begin
        c.cond   = C_ALWAYS;
        c.target = S_WAIT;
      end
      S_LOAD: begin
        c.cond   = C_LOAD_SKIP;
        c.target = S_WAIT;
      end
      S_LD_CHK_IN: begin
        c.cond   = C_NOT_INSIDE;
        c.target = S_LD_WRITE;
      end
      S_LD_OLD_RD: begin
        c.st_rd  = 1'b1;
        c.st_sel = ST_LOAD_IDX;
      end
      S_LD_OLD_PAR: c.par_rd = 1'b1;
      S_LD_OLD_UPD: c.par_op = PO_REMOVE;
      S_LD_WRITE: begin
        c.st_wr  = 1'b1;
        c.st_sel = ST_LOAD_IDX;
        c.cond   = C_NOT_INSIDE;
        c.target = S_WAIT;
      end
      S_LD_NEW_PAR: begin
        c.par_rd  = 1'b1;
        c.par_sel = PS_LOAD_VAL;
      end
      S_LD_NEW_UPD: begin
        c.par_op  = PO_ADD;
        c.par_sel = PS_LOAD_VAL;
        c.cond    = C_ALWAYS;
        c.target  = S_WAIT;
      end
      default: begin
        c.cond   = C_ALWAYS;
        c.target = S_WAIT;
      end
    endcase
    return c;
  endfunction

endpackage

[sv/swpc_seq.sv]
// ----------------------------------------------------------------------------
// swpc_seq
// Step counter and microprogram table with conditional jumps.
// ----------------------------------------------------------------------------
module swpc_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_fire_i,
  input  logic               out_full_i,
  input  swpc_pkg::dp_flags_t flags_i,
  output swpc_pkg::ctrl_t    ctrl_o
);

  swpc_pkg::step_t step_q, step_d;
  swpc_pkg::ctrl_t ctrl;
  logic            taken;

  assign ctrl   = swpc_pkg::ucode(step_q);
  assign ctrl_o = ctrl;

  always_comb begin
    case (ctrl.cond)
      swpc_pkg::C_ALWAYS:      taken = 1'b1;
      swpc_pkg::C_NEVER:       taken = 1'b0;
      swpc_pkg::C_NO_FIRE:     taken = ~in_fire_i;
      swpc_pkg::C_IS_LOAD:     taken = flags_i.is_load;
      swpc_pkg::C_REVERSED:    taken = flags_i.reversed;
      swpc_pkg::C_END_GE_QE:   taken = flags_i.end_ge_qe;
      swpc_pkg::C_START_LE_QS: taken = flags_i.start_le_qs;
      swpc_pkg::C_START_GE_QS: taken = flags_i.start_ge_qs;
      swpc_pkg::C_END_LE_QE:   taken = flags_i.end_le_qe;
      swpc_pkg::C_NOT_INSIDE:  taken = flags_i.not_inside;
      swpc_pkg::C_LOAD_SKIP:   taken = flags_i.load_skip;
      swpc_pkg::C_OUT_FULL:    taken = out_full_i;
      swpc_pkg::C_CLR_BUSY:    taken = flags_i.clr_busy;
      default:                 taken = 1'b0;
    endcase
  end

  assign step_d = taken ? ctrl.target : step_q + swpc_pkg::step_t'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= swpc_pkg::S_CLEAR;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

[sv/swpc_dp.sv]
// ----------------------------------------------------------------------------
// swpc_dp
// Request latch, window bounds, element store, count-parity store and
// running pair total.
// ----------------------------------------------------------------------------
module swpc_dp #(
  parameter int MAX_ELEMENTS = 1024,
  parameter int MAX_VALUES   = 1024
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  swpc_pkg::ctrl_t                        ctrl_i,
  input  logic                                   latch_i,
  input  logic                                   operation_i,
  input  logic [swpc_pkg::ELEM_INDEX_W-1:0]      element_index_i,
  input  logic [swpc_pkg::ELEM_VALUE_W-1:0]      element_value_i,
  input  logic [swpc_pkg::RANGE_W-1:0]           range_start_i,
  input  logic [swpc_pkg::RANGE_W-1:0]           range_end_i,
  output swpc_pkg::dp_flags_t                    flags_o,
  output logic [swpc_pkg::PAIR_COUNT_W-1:0]      pair_count_o
);

  localparam int AddrW  = $clog2(MAX_ELEMENTS);
  localparam int WinW   = $clog2(MAX_ELEMENTS + 1);
  localparam int ValW   = $clog2(MAX_VALUES);
  localparam int PairNW = $clog2(MAX_ELEMENTS / 2 + 1);
  localparam int PairW  = (PairNW > swpc_pkg::PAIR_COUNT_W) ? PairNW : swpc_pkg::PAIR_COUNT_W;

  logic                              req_load_q;
  logic                              req_rev_q;
  logic [swpc_pkg::ELEM_INDEX_W-1:0] req_idx_q;
  logic [ValW-1:0]                   req_val_q;
  logic [WinW-1:0]                   req_qs_q;
  logic [WinW-1:0]                   req_qe_q;

  logic [WinW-1:0]  win_start_q, win_start_d;
  logic [WinW-1:0]  win_end_q, win_end_d;
  logic [PairW-1:0] pair_q, pair_d;
  logic [ValW-1:0]  clr_q;

  logic [ValW-1:0]  store_mem [MAX_ELEMENTS];
  logic             par_mem [MAX_VALUES];
  logic [ValW-1:0]  st_rdata_q;
  logic             par_rdata_q;

  logic [AddrW-1:0] st_addr;
  logic [ValW-1:0]  par_addr;
  logic             in_window;

  // Hold the request with saturated operands
  always_ff @(posedge clk_i) begin
    if (latch_i) begin
      req_load_q <= (operation_i == swpc_pkg::OP_LOAD);
      req_rev_q  <= range_start_i > range_end_i;
      req_idx_q  <= element_index_i;
      req_val_q  <= (32'(element_value_i) >= MAX_VALUES) ? ValW'(MAX_VALUES - 1)
                                                         : ValW'(element_value_i);
      req_qs_q   <= (32'(range_start_i) > MAX_ELEMENTS) ? WinW'(MAX_ELEMENTS)
                                                        : WinW'(range_start_i);
      req_qe_q   <= (32'(range_end_i) > MAX_ELEMENTS) ? WinW'(MAX_ELEMENTS)
                                                      : WinW'(range_end_i);
    end
  end

  assign in_window = (32'(req_idx_q) >= 32'(win_start_q)) &&
                     (32'(req_idx_q) < 32'(win_end_q));

  assign flags_o.is_load     = req_load_q;
  assign flags_o.reversed    = req_rev_q;
  assign flags_o.end_ge_qe   = win_end_q >= req_qe_q;
  assign flags_o.start_le_qs = win_start_q <= req_qs_q;
  assign flags_o.start_ge_qs = win_start_q >= req_qs_q;
  assign flags_o.end_le_qe   = win_end_q <= req_qe_q;
  assign flags_o.not_inside  = ~in_window;
  assign flags_o.load_skip   = 32'(req_idx_q) >= MAX_ELEMENTS;
  assign flags_o.clr_busy    = clr_q != ValW'(MAX_VALUES - 1);

  always_comb begin
    case (ctrl_i.st_sel)
      swpc_pkg::ST_END:      st_addr = AddrW'(win_end_q);
      swpc_pkg::ST_START_M1: st_addr = AddrW'(win_start_q - WinW'(1));
      swpc_pkg::ST_START:    st_addr = AddrW'(win_start_q);
      swpc_pkg::ST_END_M1:   st_addr = AddrW'(win_end_q - WinW'(1));
      swpc_pkg::ST_LOAD_IDX: st_addr = AddrW'(req_idx_q);
      default:               st_addr = AddrW'(win_end_q);
    endcase
  end

  always_comb begin
    if (ctrl_i.par_op == swpc_pkg::PO_CLEAR) begin
      par_addr = clr_q;
    end else if (ctrl_i.par_sel == swpc_pkg::PS_LOAD_VAL) begin
      par_addr = req_val_q;
    end else begin
      par_addr = st_rdata_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.st_wr) begin
      store_mem[st_addr] <= req_val_q;
    end
    if (ctrl_i.st_rd) begin
      st_rdata_q <= store_mem[st_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.par_op == swpc_pkg::PO_CLEAR) begin
      par_mem[par_addr] <= 1'b0;
    end else if (ctrl_i.par_op != swpc_pkg::PO_NONE) begin
      par_mem[par_addr] <= ~par_rdata_q;
    end
    if (ctrl_i.par_rd) begin
      par_rdata_q <= par_mem[par_addr];
    end
  end

  always_comb begin
    win_start_d = win_start_q;
    win_end_d   = win_end_q;
    case (ctrl_i.win_op)
      swpc_pkg::WO_INC_END:   win_end_d   = win_end_q + WinW'(1);
      swpc_pkg::WO_DEC_START: win_start_d = win_start_q - WinW'(1);
      swpc_pkg::WO_INC_START: win_start_d = win_start_q + WinW'(1);
      swpc_pkg::WO_DEC_END:   win_end_d   = win_end_q - WinW'(1);
      default: ;
    endcase
  end

  // An odd count turning even adds a pair; an even count turning odd drops one
  always_comb begin
    pair_d = pair_q;
    case (ctrl_i.par_op)
      swpc_pkg::PO_ADD: begin
        if (par_rdata_q) pair_d = pair_q + PairW'(1);
      end
      swpc_pkg::PO_REMOVE: begin
        if (!par_rdata_q && pair_q != '0) pair_d = pair_q - PairW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_start_q <= '0;
      win_end_q   <= '0;
      pair_q      <= '0;
      clr_q       <= '0;
    end else begin
      win_start_q <= win_start_d;
      win_end_q   <= win_end_d;
      pair_q      <= pair_d;
      if (ctrl_i.par_op == swpc_pkg::PO_CLEAR && flags_o.clr_busy) begin
        clr_q <= clr_q + ValW'(1);
      end
    end
  end

  assign pair_count_o = pair_q[swpc_pkg::PAIR_COUNT_W-1:0];

endmodule

[sv/sliding_window_pair_counter.sv]
// ----------------------------------------------------------------------------
// sliding_window_pair_counter
// Range-query engine counting equal-value pairs in a sliding window.
// ----------------------------------------------------------------------------
// Loads write one value into the element store; queries return the number of
// disjoint equal-value pairs in [range_start, range_end), or a range error for
// a reversed range. The window moves one element at a time under a microcoded
// sequencer; each element moved costs a loop of bound check, store read,
// count-parity read and parity write with pair update. A query waits to emit
// while the output register stays full, and a load whose index lies inside
// the window also takes the old value out of the pair total and adds the new
// one, while a load whose index lies beyond the store is dropped. After reset
// the count-parity store is cleared, during which no request is taken.
// One request is worked at a time; a finished result waits in the output
// register while the next request is taken.
module sliding_window_pair_counter #(
  parameter int MAX_ELEMENTS = 1024,
  parameter int MAX_VALUES   = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [9:0] element_index, [19:10] element_value, [30:20] range_start,
  // [41:31] range_end, [47:42] zero
  input  logic [swpc_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // [0] operation
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [9:0] pair_count, [15:10] zero
  output logic [swpc_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  // [0] range_error
  output logic                               m_axis_tuser
);

  swpc_pkg::ctrl_t     ctrl;
  swpc_pkg::dp_flags_t flags;
  logic                in_fire;
  logic                out_full;
  logic                emit_fire;
  logic [swpc_pkg::PAIR_COUNT_W-1:0] pair_count;

  logic                              out_valid_q;
  logic [swpc_pkg::PAIR_COUNT_W-1:0] out_pair_q;
  logic                              out_err_q;

  assign s_axis_tready = ctrl.in_ready;
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign out_full      = out_valid_q & ~m_axis_tready;
  assign emit_fire     = ctrl.emit & ~out_full;

  swpc_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .out_full_i (out_full),
    .flags_i    (flags),
    .ctrl_o     (ctrl)
  );

  swpc_dp #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .MAX_VALUES   (MAX_VALUES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .latch_i         (in_fire),
    .operation_i     (s_axis_tuser),
    .element_index_i (s_axis_tdata[9:0]),
    .element_value_i (s_axis_tdata[19:10]),
    .range_start_i   (s_axis_tdata[30:20]),
    .range_end_i     (s_axis_tdata[41:31]),
    .flags_o         (flags),
    .pair_count_o    (pair_count)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      out_pair_q <= flags.reversed ? '0 : pair_count;
      out_err_q  <= flags.reversed;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(swpc_pkg::M_TDATA_W - swpc_pkg::PAIR_COUNT_W){1'b0}}, out_pair_q};
  assign m_axis_tuser  = out_err_q;

  a_one_request_at_a_time: assert property (
    @(posedge clk_i) disable iff (!rst_ni) in_fire |=> !s_axis_tready
  ) else $error("request taken while previous one in progress");

  a_result_only_for_query: assert property (
    @(posedge clk_i) disable iff (!rst_ni) emit_fire |-> !flags.is_load
  ) else $error("result produced for a load");

  a_error_has_zero_count: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0)
  ) else $error("range error result carries a pair count");

endmodule

[verif/sliding_window_pair_counter_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_pair_counter_tb
// Self-checking bench for the sliding-window equal-value pair counter.
// ----------------------------------------------------------------------------
// A short table of directed requests is followed by random loads and
// queries. Most queries move the window a little; a few jump far or go past
// the end of the store. Every query result is checked against a local
// window/histogram predictor, or against the table for typed directed rows.
// Store entries are loaded before any query window walk can reach them.
// Both stream sides idle and stall at random.
module sliding_window_pair_counter_tb;

  localparam logic OP_LOAD       = swpc_pkg::OP_LOAD;
  localparam logic OP_QUERY      = swpc_pkg::OP_QUERY;
  localparam int   STORE_DEPTH   = 1024;
  localparam int   VALUE_DEPTH   = 1024;
  localparam int   RANGE_TOP     = 2047;
  localparam int   RANDOM_ITEMS  = 1800;
  localparam int   IDLE_LIMIT    = 40000;
  localparam int   SETTLE_CYCLES = 64;
  localparam int   DIRECTED_ROWS = 23;

  typedef struct packed {
    logic [swpc_pkg::PAIR_COUNT_W-1:0] pair_count;
    logic                              range_error;
  } pair_result_t;

  typedef struct packed {
    logic                              op;
    logic [swpc_pkg::ELEM_INDEX_W-1:0] idx;
    logic [swpc_pkg::ELEM_VALUE_W-1:0] val;
    logic [swpc_pkg::RANGE_W-1:0]      qs;
    logic [swpc_pkg::RANGE_W-1:0]      qe;
    logic                              typed;
    pair_result_t                      res;
  } stim_row_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [swpc_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
  logic                           s_axis_tuser = 1'b0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [swpc_pkg::M_TDATA_W-1:0] m_axis_tdata;
  logic                           m_axis_tuser;

  logic [swpc_pkg::ELEM_VALUE_W-1:0] stored_value [STORE_DEPTH];
  bit                                stored_valid [STORE_DEPTH];
  int unsigned                       tally [VALUE_DEPTH];
  int                                win_lo;
  int                                win_hi;
  int unsigned                       pairs_now;
  pair_result_t                      expected_results [$];
  pair_result_t                      head;
  int                                failures;
  int                                items_sent;
  bit                                send_calm;
  bit                                sink_calm;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{OP_QUERY, 10'd0,    10'd0,    11'd0,    11'd0,    1'b1, '{10'd0, 1'b0}},
    '{OP_QUERY, 10'd0,    10'd0,    11'd2047, 11'd0,    1'b1, '{10'd0, 1'b1}},
    '{OP_QUERY, 10'd1023, 10'd1023, 11'd1,    11'd0,    1'b1, '{10'd0, 1'b1}},
    '{OP_QUERY, 10'd0,    10'd0,    11'd2047, 11'd2046, 1'b1, '{10'd0, 1'b1}},
    '{OP_QUERY, 10'd0,    10'd0,    11'd1025, 11'd1024, 1'b1, '{10'd0, 1'b1}},
    '{OP_LOAD,  10'd0,    10'd0,    11'd2047, 11'd2047, 1'b0, '{10'd0, 1'b0}},
    '{OP_LOAD,  10'd1,    10'd0,    11'd0,    11'd0,    1'b0, '{10'd0, 1'b0}},
    '{OP_LOAD,  10'd2,    10'd1023, 11'd0,    11'd0,    1'b0, '{10'd0, 1'b0}},
    '{OP_LOAD,  10'd3,    10'd1023, 11'd0,    11'd0,    1'b0, '{10'd0, 1'b0}},
    '{OP_LOAD,  10'd4,    10'd5,    11'd0,    11'd0,    1'b0, '{10'd0, 1'b0}},
    '{OP_QUERY, 10'd0,    10'd0,    11'd0,    11'd4,    1'b1, '{10'd2, 1'b0}},
    '{OP_QUERY, 10'd0,    10'd0,    11'd1,    11'd3,    1'b1, '{10'd0, 1'b0}},
    '{OP_LOAD,  10'd1,    10'd1023, 11'd0,    11'd0,    1'b0, '{10'd0, 1'b0}},
    '{OP_QUERY, 10'd0,    10'd0,    11'd1,    11'd4,    1'b0, '{10'd0, 1'b0}},
    '{OP_QUERY, 10'd0,    10'd0,    11'd0,    11'd5,    1'b0, '{10'd0, 1'b0}},
    '{OP_LOAD,  10'd1023, 10'd1023, 11'd0,    11'd0,    1'b0, '{10'd0, 1'b0}},
    '{OP_LOAD,  10'd1022, 10'd1023, 11'd0,    11'd0,    1'b0, '{10'd0, 1'b0}},
    '{OP_LOAD,  10'd512,  10'd512,  11'd0,    11'd0,    1'b0, '{10'd0, 1'b0}},
    '{OP_LOAD,  10'd4,    10'd0,    11'd0,    11'd0,    1'b0, '{10'd0, 1'b0}},
    '{OP_QUERY, 10'd0,    10'd0,    11'd2,    11'd2,    1'b0, '{10'd0, 1'b0}},
    '{OP_QUERY, 10'd0,    10'd0,    11'd3,    11'd5,    1'b0, '{10'd0, 1'b0}},
    '{OP_QUERY, 10'd0,    10'd0,    11'd0,    11'd0,    1'b1, '{10'd0, 1'b0}},
    '{OP_QUERY, 10'd0,    10'd0,    11'd1024, 11'd0,    1'b1, '{10'd0, 1'b1}}
  };

  sliding_window_pair_counter dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic void tally_add(input logic [swpc_pkg::ELEM_VALUE_W-1:0] v);
    tally[v]++;
    if (tally[v][0] == 1'b0) pairs_now++;
  endfunction

  function automatic void tally_drop(input logic [swpc_pkg::ELEM_VALUE_W-1:0] v);
    if (tally[v] == 0) return;
    tally[v]--;
    if (tally[v][0] == 1'b1 && pairs_now > 0) pairs_now--;
  endfunction

  function automatic void apply_load(input logic [swpc_pkg::ELEM_INDEX_W-1:0] idx,
                                     input logic [swpc_pkg::ELEM_VALUE_W-1:0] val);
    bit in_win;
    in_win = (int'(idx) >= win_lo) && (int'(idx) < win_hi);
    if (in_win) tally_drop(stored_value[idx]);
    stored_value[idx] = val;
    stored_valid[idx] = 1'b1;
    if (in_win) tally_add(val);
  endfunction

  function automatic pair_result_t answer_query(input logic [swpc_pkg::RANGE_W-1:0] qs,
                                                input logic [swpc_pkg::RANGE_W-1:0] qe);
    int lo;
    int hi;
    pair_result_t res;
    if (qs > qe) begin
      res.pair_count  = '0;
      res.range_error = 1'b1;
      return res;
    end
    lo = (int'(qs) > STORE_DEPTH) ? STORE_DEPTH : int'(qs);
    hi = (int'(qe) > STORE_DEPTH) ? STORE_DEPTH : int'(qe);
    // widen before shrinking so no count goes below zero
    while (win_hi < hi) begin
      tally_add(stored_value[win_hi]);
      win_hi++;
    end
    while (win_lo > lo) begin
      win_lo--;
      tally_add(stored_value[win_lo]);
    end
    while (win_lo < lo) begin
      tally_drop(stored_value[win_lo]);
      win_lo++;
    end
    while (win_hi > hi) begin
      win_hi--;
      tally_drop(stored_value[win_hi]);
    end
    res.pair_count  = pairs_now[swpc_pkg::PAIR_COUNT_W-1:0];
    res.range_error = 1'b0;
    return res;
  endfunction

  function automatic int gap_len(input bit calm);
    int roll;
    if (calm) return 0;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 90);
  endfunction

  // small palette most of the time so that equal values meet often
  function automatic logic [swpc_pkg::ELEM_VALUE_W-1:0] pick_value();
    if ($urandom_range(99) < 75) return swpc_pkg::ELEM_VALUE_W'($urandom_range(7));
    return swpc_pkg::ELEM_VALUE_W'($urandom_range(VALUE_DEPTH - 1));
  endfunction

  task automatic issue_request(input logic op,
                               input logic [swpc_pkg::ELEM_INDEX_W-1:0] idx,
                               input logic [swpc_pkg::ELEM_VALUE_W-1:0] val,
                               input logic [swpc_pkg::RANGE_W-1:0] qs,
                               input logic [swpc_pkg::RANGE_W-1:0] qe,
                               input bit typed, input pair_result_t typed_res);
    int gap;
    pair_result_t res;
    gap = gap_len(send_calm);
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= swpc_pkg::S_TDATA_W'({qe, qs, val, idx});
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    if (op == OP_LOAD) begin
      apply_load(idx, val);
    end else begin
      res = answer_query(qs, qe);
      expected_results.insert(expected_results.size(), typed ? typed_res : res);
    end
  endtask

  // load every never-written entry the window walk would touch, then query
  task automatic send_query(input int qs, input int qe);
    int qs_sat;
    int qe_sat;
    int lo;
    int hi;
    if (qs <= qe) begin
      qs_sat = (qs > STORE_DEPTH) ? STORE_DEPTH : qs;
      qe_sat = (qe > STORE_DEPTH) ? STORE_DEPTH : qe;
      lo = (qs_sat < win_lo) ? qs_sat : win_lo;
      hi = (qe_sat > win_hi) ? qe_sat : win_hi;
      for (int i = lo; i < hi; i++) begin
        if (!stored_valid[i]) begin
          issue_request(OP_LOAD, swpc_pkg::ELEM_INDEX_W'(i), pick_value(),
                        swpc_pkg::RANGE_W'($urandom_range(RANGE_TOP)),
                        swpc_pkg::RANGE_W'($urandom_range(RANGE_TOP)), 1'b0, '0);
        end
      end
    end
    issue_request(OP_QUERY, swpc_pkg::ELEM_INDEX_W'($urandom_range(STORE_DEPTH - 1)),
                  swpc_pkg::ELEM_VALUE_W'($urandom_range(VALUE_DEPTH - 1)),
                  swpc_pkg::RANGE_W'(qs), swpc_pkg::RANGE_W'(qe), 1'b0, '0);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int stall;
    forever begin
      @(negedge clk_i);
      if (sink_calm) begin
        m_axis_tready <= 1'b1;
      end else if ($urandom_range(99) < 3) begin
        stall = $urandom_range(20, 80);
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end else begin
        m_axis_tready <= ($urandom_range(99) < 70);
      end
      if ($urandom_range(399) == 0) sink_calm = !sink_calm;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: pair_count %0d range_error %0b",
               m_axis_tdata[swpc_pkg::PAIR_COUNT_W-1:0], m_axis_tuser);
        failures++;
      end else begin
        head = expected_results.pop_front();
        if (m_axis_tdata[swpc_pkg::PAIR_COUNT_W-1:0] !== head.pair_count) begin
          $error("pair_count: expected %0d, actual %0d", head.pair_count,
                 m_axis_tdata[swpc_pkg::PAIR_COUNT_W-1:0]);
          failures++;
        end
        if (m_axis_tuser !== head.range_error) begin
          $error("range_error: expected %0b, actual %0b", head.range_error,
                 m_axis_tuser);
          failures++;
        end
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    int roll;
    int a;
    int b;
    int idx;
    int near_lo;
    int near_hi;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      issue_request(directed_rows[r].op, directed_rows[r].idx, directed_rows[r].val,
                    directed_rows[r].qs, directed_rows[r].qe, directed_rows[r].typed,
                    directed_rows[r].res);
    end
    drain_results();

    while (items_sent < DIRECTED_ROWS + RANDOM_ITEMS) begin
      roll = $urandom_range(99);
      if (roll < 30) begin
        if (win_hi > win_lo && $urandom_range(1) == 1) begin
          idx = $urandom_range(win_lo, win_hi - 1);
        end else if ($urandom_range(1) == 1) begin
          near_lo = (win_lo > 8) ? win_lo - 8 : 0;
          near_hi = (win_hi + 8 > STORE_DEPTH - 1) ? STORE_DEPTH - 1 : win_hi + 8;
          idx = $urandom_range(near_lo, near_hi);
        end else begin
          idx = $urandom_range(STORE_DEPTH - 1);
        end
        issue_request(OP_LOAD, swpc_pkg::ELEM_INDEX_W'(idx), pick_value(),
                      swpc_pkg::RANGE_W'($urandom_range(RANGE_TOP)),
                      swpc_pkg::RANGE_W'($urandom_range(RANGE_TOP)), 1'b0, '0);
      end else if (roll < 35) begin
        a = $urandom_range(1, RANGE_TOP);
        send_query(a, $urandom_range(0, a - 1));
      end else if (roll < 38) begin
        b = $urandom_range(STORE_DEPTH, RANGE_TOP);
        a = ($urandom_range(9) == 0) ? $urandom_range(STORE_DEPTH, b)
                                     : $urandom_range(STORE_DEPTH - 64, STORE_DEPTH);
        send_query(a, b);
      end else if (roll < 41) begin
        a = $urandom_range(STORE_DEPTH);
        b = a + $urandom_range(48);
        send_query(a, (b > STORE_DEPTH) ? STORE_DEPTH : b);
      end else begin
        a = win_lo + $urandom_range(24) - 12;
        b = win_hi + $urandom_range(24) - 12;
        a = (a < 0) ? 0 : ((a > STORE_DEPTH) ? STORE_DEPTH : a);
        if (b < a) b = a + $urandom_range(8);
        b = (b > STORE_DEPTH) ? STORE_DEPTH : b;
        if (b - a > 96) a = b - $urandom_range(96);
        send_query(a, b);
      end
      if ($urandom_range(63) == 0) send_calm = !send_calm;
      if ($urandom_range(199) == 0) drain_results();
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
